// ----- hw/rtl/triangle_setup_normals_macros.svh -----
// ----------------------------------------------------------------------------
// Triangle setup normals: assertion macros
// Concurrent assertion shorthands clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_SETUP_NORMALS_MACROS_SVH
`define TRIANGLE_SETUP_NORMALS_MACROS_SVH
`ifndef NO_ASSERTIONS
`define TSN_ASSERT(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);
`define TSN_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
`else
`define TSN_ASSERT(label, expr, msg)
`define TSN_ASSERT_IMPLY(label, ante, cons, msg)
`endif
`endif

// ----- hw/rtl/tsn_pkg.sv -----
// ----------------------------------------------------------------------------
// Triangle setup normals: package
// Shared constants, result codes and the status records between modules.
// ----------------------------------------------------------------------------
package tsn_pkg;

   localparam int VEC_WIDTH  = 32;
   localparam int AREA_WIDTH = 52;
   localparam int UNIT_FRAC  = 30;
   localparam int QUOT_BITS  = 31;

   localparam logic [1:0] KIND_NORMAL = 2'd0;
   localparam logic [1:0] KIND_AB     = 2'd1;
   localparam logic [1:0] KIND_BC     = 2'd2;
   localparam logic [1:0] KIND_CA     = 2'd3;

   localparam logic [AREA_WIDTH-1:0] AREA_MAX = '1;

   localparam int QDEPTH = 4;
   localparam int QPTR_W = 2;
   localparam int QCNT_W = 3;

   typedef struct packed {
      logic [QCNT_W-1:0] count;
      logic              full;
      logic              empty;
   } q_stat_type;

   typedef struct packed {
      logic [1:0] kind;
      logic       degenerate;
      logic       last;
   } res_ctl_type;

endpackage

// ----- hw/rtl/tsn_front.sv -----
// ----------------------------------------------------------------------------
// Triangle setup normals: front end
// Accepts triangles, forms the edges and the raw cross product, flags
// degenerate triangles and pushes each item into the queue.
// ----------------------------------------------------------------------------
module tsn_front #(
   parameter int COORD_WIDTH = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [COORD_WIDTH-1:0] req_a_x,
   input  logic signed [COORD_WIDTH-1:0] req_a_y,
   input  logic signed [COORD_WIDTH-1:0] req_a_z,
   input  logic signed [COORD_WIDTH-1:0] req_b_x,
   input  logic signed [COORD_WIDTH-1:0] req_b_y,
   input  logic signed [COORD_WIDTH-1:0] req_b_z,
   input  logic signed [COORD_WIDTH-1:0] req_c_x,
   input  logic signed [COORD_WIDTH-1:0] req_c_y,
   input  logic signed [COORD_WIDTH-1:0] req_c_z,
   input  tsn_pkg::q_stat_type           q_stat,
   output logic                          push,
   output logic [9*(COORD_WIDTH+1)+3*(2*COORD_WIDTH+3):0] push_data
);

   localparam int EW = COORD_WIDTH + 1;
   localparam int PW = 2 * EW;
   localparam int NW = PW + 1;

   logic                 v1_ff, v1_in, v2_ff;
   logic signed [EW-1:0] e1_ff [0:8];
   logic signed [EW-1:0] e1_in [0:8];
   logic signed [EW-1:0] e2_ff [0:8];
   logic signed [PW-1:0] p2_ff [0:5];
   logic signed [PW-1:0] p2_in [0:5];
   logic signed [NW-1:0] n_val [0:2];
   logic [tsn_pkg::QCNT_W-1:0] in_flight;

   // Items in the two stages are counted against the queue, so the stages never stall.
   assign in_flight = q_stat.count + tsn_pkg::QCNT_W'(v1_ff) + tsn_pkg::QCNT_W'(v2_ff);
   assign req_stall = in_flight >= tsn_pkg::QCNT_W'(tsn_pkg::QDEPTH);
   assign v1_in     = req_valid && !req_stall;

   // Edges ab, bc and ca, x y z each.
   always_comb begin
      e1_in[0] = EW'(req_b_x) - EW'(req_a_x);
      e1_in[1] = EW'(req_b_y) - EW'(req_a_y);
      e1_in[2] = EW'(req_b_z) - EW'(req_a_z);
      e1_in[3] = EW'(req_c_x) - EW'(req_b_x);
      e1_in[4] = EW'(req_c_y) - EW'(req_b_y);
      e1_in[5] = EW'(req_c_z) - EW'(req_b_z);
      e1_in[6] = EW'(req_a_x) - EW'(req_c_x);
      e1_in[7] = EW'(req_a_y) - EW'(req_c_y);
      e1_in[8] = EW'(req_a_z) - EW'(req_c_z);
   end

   always_comb begin
      p2_in[0] = PW'(e1_ff[2]) * PW'(e1_ff[7]);
      p2_in[1] = PW'(e1_ff[1]) * PW'(e1_ff[8]);
      p2_in[2] = PW'(e1_ff[0]) * PW'(e1_ff[8]);
      p2_in[3] = PW'(e1_ff[2]) * PW'(e1_ff[6]);
      p2_in[4] = PW'(e1_ff[1]) * PW'(e1_ff[6]);
      p2_in[5] = PW'(e1_ff[0]) * PW'(e1_ff[7]);
   end

   always_comb begin
      n_val[0] = NW'(p2_ff[0]) - NW'(p2_ff[1]);
      n_val[1] = NW'(p2_ff[2]) - NW'(p2_ff[3]);
      n_val[2] = NW'(p2_ff[4]) - NW'(p2_ff[5]);
      push_data = '0;
      for (int k = 0; k < 9; k++) begin
         push_data[k*EW +: EW] = e2_ff[k];
      end
      for (int i = 0; i < 3; i++) begin
         push_data[9*EW + i*NW +: NW] = n_val[i];
      end
      push_data[9*EW + 3*NW] = (n_val[0] == '0) && (n_val[1] == '0) && (n_val[2] == '0);
   end

   assign push = v2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v1_ff;
      end
      e1_ff <= e1_in;
      e2_ff <= e1_ff;
      p2_ff <= p2_in;
   end

endmodule

// ----- hw/rtl/tsn_queue.sv -----
// ----------------------------------------------------------------------------
// Triangle setup normals: item queue
// Short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module tsn_queue #(
   parameter int DATA_WIDTH = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  logic [DATA_WIDTH-1:0] push_data,
   input  logic                  pop,
   output logic [DATA_WIDTH-1:0] head,
   output tsn_pkg::q_stat_type   q_stat
);

   logic [DATA_WIDTH-1:0]          mem_ff [0:tsn_pkg::QDEPTH-1];
   logic [tsn_pkg::QPTR_W-1:0]     wr_ff, wr_in, rd_ff, rd_in;
   logic [tsn_pkg::QCNT_W-1:0]     cnt_ff, cnt_in;

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + tsn_pkg::QCNT_W'(push) - tsn_pkg::QCNT_W'(pop);
   end

   assign head         = mem_ff[rd_ff];
   assign q_stat.count = cnt_ff;
   assign q_stat.full  = cnt_ff == tsn_pkg::QCNT_W'(tsn_pkg::QDEPTH);
   assign q_stat.empty = cnt_ff == '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

// ----- hw/rtl/tsn_back.sv -----
// ----------------------------------------------------------------------------
// Triangle setup normals: back end
// Serial sum of squares, square root and division for the unit normal, then
// the edge normals of ab, bc, ca, through an output register, unless degenerate.
// ----------------------------------------------------------------------------
module tsn_back #(
   parameter int COORD_WIDTH = 24
) (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           q_valid,
   input  logic [9*(COORD_WIDTH+1)+3*(2*COORD_WIDTH+3):0] q_data,
   output logic                                           q_pop,
   input  logic                                           rsp_stall,
   output logic                                           rsp_valid,
   output tsn_pkg::res_ctl_type                           rsp_ctl,
   output logic signed [tsn_pkg::VEC_WIDTH-1:0]           rsp_vec_x,
   output logic signed [tsn_pkg::VEC_WIDTH-1:0]           rsp_vec_y,
   output logic signed [tsn_pkg::VEC_WIDTH-1:0]           rsp_vec_z,
   output logic [tsn_pkg::AREA_WIDTH-1:0]                 rsp_area
);

   localparam int EW   = COORD_WIDTH + 1;
   localparam int NW   = 2 * EW + 1;
   localparam int MW   = 2 * EW;
   localparam int SW   = 2 * MW;
   localparam int RW   = MW;
   localparam int VW   = tsn_pkg::VEC_WIDTH;
   localparam int QB   = tsn_pkg::QUOT_BITS;
   localparam int PRW  = VW + EW;
   localparam int DFW  = PRW + 1;
   localparam int SHW  = DFW - tsn_pkg::UNIT_FRAC;
   localparam int GW   = (SHW > VW + 1) ? SHW : VW + 1;
   localparam int HW   = RW - 1;
   localparam int XW   = (HW > tsn_pkg::AREA_WIDTH) ? HW : tsn_pkg::AREA_WIDTH;
   localparam int MAXC = (MW > QB) ? MW : QB;
   localparam int CNTW = $clog2(MAXC);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_SQ   = 3'd1;
   localparam logic [2:0] ST_RT   = 3'd2;
   localparam logic [2:0] ST_DV   = 3'd3;
   localparam logic [2:0] ST_OUTN = 3'd4;
   localparam logic [2:0] ST_MUL  = 3'd5;
   localparam logic [2:0] ST_OUTE = 3'd6;
   localparam logic [2:0] ST_OUTD = 3'd7;

   function automatic logic signed [VW-1:0] sat_shift(input logic signed [DFW-1:0] d);
      logic signed [GW-1:0] s;
      logic [GW-VW:0]       hi;
      s  = GW'(d >>> tsn_pkg::UNIT_FRAC);
      hi = s[GW-1:VW-1];
      if ((hi == '0) || (hi == '1)) begin
         return s[VW-1:0];
      end else if (s[GW-1]) begin
         return {1'b1, {(VW-1){1'b0}}};
      end else begin
         return {1'b0, {(VW-1){1'b1}}};
      end
   endfunction

   logic [2:0]           state_ff, state_in;
   logic [1:0]           ci_ff, ci_in, ei_ff, ei_in;
   logic [CNTW-1:0]      step_ff, step_in;
   logic signed [EW-1:0] e_ff [0:8];
   logic signed [EW-1:0] e_in [0:8];
   logic [MW-1:0]        nm_ff [0:2];
   logic [MW-1:0]        nm_in [0:2];
   logic [2:0]           nneg_ff, nneg_in;
   logic [SW-1:0]        acc_ff, acc_in, msh_ff, msh_in;
   logic [MW-1:0]        mbits_ff, mbits_in;
   logic [RW+1:0]        rem_ff, rem_in;
   logic [RW-1:0]        root_ff, root_in;
   logic [RW-1:0]        dr_ff, dr_in;
   logic [QB-1:0]        quo_ff, quo_in;
   logic signed [VW-1:0] u_ff [0:2];
   logic signed [VW-1:0] u_in [0:2];
   logic signed [PRW-1:0] p_ff [0:5];
   logic signed [PRW-1:0] p_in [0:5];

   logic                 valid_ff, valid_in, load;
   tsn_pkg::res_ctl_type ctl_ff, ctl_in;
   logic signed [VW-1:0] vx_ff, vx_in, vy_ff, vy_in, vz_ff, vz_in;
   logic [tsn_pkg::AREA_WIDTH-1:0] area_ff, area_in, area_val;
   logic                 out_free;

   logic signed [EW-1:0] qe [0:8];
   logic signed [NW-1:0] qn [0:2];
   logic [NW-1:0]        qmag [0:2];
   logic [MW-1:0]        nm_cur, nm_nxt;
   logic                 neg_cur;
   logic [RW+1:0]        rt_remn, rt_trial;
   logic                 rt_ge;
   logic [RW:0]          dv_t, dv_rem;
   logic                 dv_ge;
   logic [QB-1:0]        quo_next;
   logic [VW-1:0]        quo_ext;
   logic signed [EW-1:0] sx, sy, sz;
   logic [XW-1:0]        halfx;
   logic [1:0]           edge_kind;

   always_comb begin
      for (int k = 0; k < 9; k++) begin
         qe[k] = $signed(q_data[k*EW +: EW]);
      end
      for (int i = 0; i < 3; i++) begin
         qn[i]   = $signed(q_data[9*EW + i*NW +: NW]);
         qmag[i] = qn[i][NW-1] ? NW'(-qn[i]) : NW'(qn[i]);
      end
   end

   always_comb begin
      case (ci_ff)
         2'd0: begin
            nm_cur = nm_ff[0]; nm_nxt = nm_ff[1]; neg_cur = nneg_ff[0];
         end
         2'd1: begin
            nm_cur = nm_ff[1]; nm_nxt = nm_ff[2]; neg_cur = nneg_ff[1];
         end
         default: begin
            nm_cur = nm_ff[2]; nm_nxt = nm_ff[2]; neg_cur = nneg_ff[2];
         end
      endcase
      case (ei_ff)
         2'd0: begin
            sx = e_ff[0]; sy = e_ff[1]; sz = e_ff[2]; edge_kind = tsn_pkg::KIND_AB;
         end
         2'd1: begin
            sx = e_ff[3]; sy = e_ff[4]; sz = e_ff[5]; edge_kind = tsn_pkg::KIND_BC;
         end
         default: begin
            sx = e_ff[6]; sy = e_ff[7]; sz = e_ff[8]; edge_kind = tsn_pkg::KIND_CA;
         end
      endcase
   end

   // One root bit per cycle: two radicand bits enter the remainder each step.
   assign rt_remn  = {rem_ff[RW-1:0], acc_ff[SW-1 -: 2]};
   assign rt_trial = {root_ff, 2'b01};
   assign rt_ge    = rt_remn >= rt_trial;

   // Restoring division; the first step tests the unshifted magnitude for bit 30.
   assign dv_t     = (step_ff == '0) ? {1'b0, dr_ff} : {dr_ff, 1'b0};
   assign dv_ge    = dv_t >= {1'b0, root_ff};
   assign dv_rem   = dv_ge ? dv_t - {1'b0, root_ff} : dv_t;
   assign quo_next = {quo_ff[QB-2:0], dv_ge};
   assign quo_ext  = {{(VW-QB){1'b0}}, quo_next};

   assign halfx    = XW'(root_ff[RW-1:1]);
   assign area_val = (halfx > XW'(tsn_pkg::AREA_MAX)) ? tsn_pkg::AREA_MAX :
                     halfx[tsn_pkg::AREA_WIDTH-1:0];

   assign out_free = !valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      ci_in    = ci_ff;
      ei_in    = ei_ff;
      step_in  = step_ff;
      e_in     = e_ff;
      nm_in    = nm_ff;
      nneg_in  = nneg_ff;
      acc_in   = acc_ff;
      msh_in   = msh_ff;
      mbits_in = mbits_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      dr_in    = dr_ff;
      quo_in   = quo_ff;
      u_in     = u_ff;
      p_in     = p_ff;
      q_pop    = 1'b0;
      load     = 1'b0;
      ctl_in   = ctl_ff;
      vx_in    = vx_ff;
      vy_in    = vy_ff;
      vz_in    = vz_ff;
      area_in  = area_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               for (int k = 0; k < 9; k++) begin
                  e_in[k] = qe[k];
               end
               for (int i = 0; i < 3; i++) begin
                  nm_in[i]   = qmag[i][MW-1:0];
                  nneg_in[i] = qn[i][NW-1];
               end
               ci_in    = 2'd0;
               step_in  = '0;
               acc_in   = '0;
               msh_in   = SW'(qmag[0][MW-1:0]);
               mbits_in = qmag[0][MW-1:0];
               state_in = q_data[9*EW + 3*NW] ? ST_OUTD : ST_SQ;
            end
         end
         ST_SQ: begin
            if (mbits_ff[0]) begin
               acc_in = acc_ff + msh_ff;
            end
            msh_in   = {msh_ff[SW-2:0], 1'b0};
            mbits_in = {1'b0, mbits_ff[MW-1:1]};
            step_in  = step_ff + 1'b1;
            if (step_ff == CNTW'(MW - 1)) begin
               step_in = '0;
               if (ci_ff == 2'd2) begin
                  rem_in   = '0;
                  root_in  = '0;
                  state_in = ST_RT;
               end else begin
                  ci_in    = ci_ff + 1'b1;
                  msh_in   = SW'(nm_nxt);
                  mbits_in = nm_nxt;
               end
            end
         end
         ST_RT: begin
            acc_in  = {acc_ff[SW-3:0], 2'b00};
            rem_in  = rt_ge ? rt_remn - rt_trial : rt_remn;
            root_in = {root_ff[RW-2:0], rt_ge};
            step_in = step_ff + 1'b1;
            if (step_ff == CNTW'(RW - 1)) begin
               step_in  = '0;
               ci_in    = 2'd0;
               dr_in    = nm_ff[0];
               quo_in   = '0;
               state_in = ST_DV;
            end
         end
         ST_DV: begin
            dr_in   = dv_rem[RW-1:0];
            quo_in  = quo_next;
            step_in = step_ff + 1'b1;
            if (step_ff == CNTW'(QB - 1)) begin
               u_in[ci_ff] = neg_cur ? -quo_ext : quo_ext;
               step_in     = '0;
               if (ci_ff == 2'd2) begin
                  state_in = ST_OUTN;
               end else begin
                  ci_in = ci_ff + 1'b1;
                  dr_in = nm_nxt;
               end
            end
         end
         ST_OUTN: begin
            if (out_free) begin
               load     = 1'b1;
               ctl_in   = '{kind: tsn_pkg::KIND_NORMAL, degenerate: 1'b0, last: 1'b0};
               vx_in    = u_ff[0];
               vy_in    = u_ff[1];
               vz_in    = u_ff[2];
               area_in  = area_val;
               ei_in    = 2'd0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            p_in[0]  = PRW'(u_ff[1]) * PRW'(sz);
            p_in[1]  = PRW'(u_ff[2]) * PRW'(sy);
            p_in[2]  = PRW'(u_ff[2]) * PRW'(sx);
            p_in[3]  = PRW'(u_ff[0]) * PRW'(sz);
            p_in[4]  = PRW'(u_ff[0]) * PRW'(sy);
            p_in[5]  = PRW'(u_ff[1]) * PRW'(sx);
            state_in = ST_OUTE;
         end
         ST_OUTE: begin
            if (out_free) begin
               load    = 1'b1;
               ctl_in  = '{kind: edge_kind, degenerate: 1'b0, last: ei_ff == 2'd2};
               vx_in   = sat_shift(DFW'(p_ff[0]) - DFW'(p_ff[1]));
               vy_in   = sat_shift(DFW'(p_ff[2]) - DFW'(p_ff[3]));
               vz_in   = sat_shift(DFW'(p_ff[4]) - DFW'(p_ff[5]));
               area_in = area_val;
               if (ei_ff == 2'd2) begin
                  state_in = ST_IDLE;
               end else begin
                  ei_in    = ei_ff + 1'b1;
                  state_in = ST_MUL;
               end
            end
         end
         ST_OUTD: begin
            if (out_free) begin
               load     = 1'b1;
               ctl_in   = '{kind: tsn_pkg::KIND_NORMAL, degenerate: 1'b1, last: 1'b1};
               vx_in    = '0;
               vy_in    = '0;
               vz_in    = '0;
               area_in  = '0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      valid_in = load || (valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
         ci_ff    <= '0;
         ei_ff    <= '0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         ci_ff    <= ci_in;
         ei_ff    <= ei_in;
         step_ff  <= step_in;
      end
      e_ff     <= e_in;
      nm_ff    <= nm_in;
      nneg_ff  <= nneg_in;
      acc_ff   <= acc_in;
      msh_ff   <= msh_in;
      mbits_ff <= mbits_in;
      rem_ff   <= rem_in;
      root_ff  <= root_in;
      dr_ff    <= dr_in;
      quo_ff   <= quo_in;
      u_ff     <= u_in;
      p_ff     <= p_in;
      ctl_ff   <= ctl_in;
      vx_ff    <= vx_in;
      vy_ff    <= vy_in;
      vz_ff    <= vz_in;
      area_ff  <= area_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_ctl   = ctl_ff;
   assign rsp_vec_x = vx_ff;
   assign rsp_vec_y = vy_ff;
   assign rsp_vec_z = vz_ff;
   assign rsp_area  = area_ff;

endmodule

// ----- hw/rtl/triangle_setup_normals.sv -----
// An accepted item is registered as edges, then as products, and then pushed to the queue.
// The back end takes one item at a time, held by the bit-serial sum of squares, square
// root and divider, and emits a degenerate item as one record, any other as four; the
// front end and a 4-entry queue keep accepting meanwhile, while there is room.
// Reset: synchronous, active high; clears the queue, the stage valids and the sequencer.
// ----------------------------------------------------------------------------
// Triangle setup normals: top level
// Unit normal, edge normals and area of a triangle in fixed point.
// ----------------------------------------------------------------------------
`include "triangle_setup_normals_macros.svh"

module triangle_setup_normals #(
   parameter int COORD_WIDTH = 24
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [COORD_WIDTH-1:0]        req_a_x,
   input  logic signed [COORD_WIDTH-1:0]        req_a_y,
   input  logic signed [COORD_WIDTH-1:0]        req_a_z,
   input  logic signed [COORD_WIDTH-1:0]        req_b_x,
   input  logic signed [COORD_WIDTH-1:0]        req_b_y,
   input  logic signed [COORD_WIDTH-1:0]        req_b_z,
   input  logic signed [COORD_WIDTH-1:0]        req_c_x,
   input  logic signed [COORD_WIDTH-1:0]        req_c_y,
   input  logic signed [COORD_WIDTH-1:0]        req_c_z,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [1:0]                           rsp_vector_kind,
   output logic signed [tsn_pkg::VEC_WIDTH-1:0] rsp_vec_x,
   output logic signed [tsn_pkg::VEC_WIDTH-1:0] rsp_vec_y,
   output logic signed [tsn_pkg::VEC_WIDTH-1:0] rsp_vec_z,
   output logic [tsn_pkg::AREA_WIDTH-1:0]       rsp_area,
   output logic                                 rsp_degenerate,
   output logic                                 rsp_last
);

   localparam int QW = 9 * (COORD_WIDTH + 1) + 3 * (2 * COORD_WIDTH + 3) + 1;

   tsn_pkg::q_stat_type  q_stat;
   tsn_pkg::res_ctl_type rsp_ctl;
   logic                 push, pop;
   logic [QW-1:0]        push_data, head;

   tsn_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_a_x   (req_a_x),
      .req_a_y   (req_a_y),
      .req_a_z   (req_a_z),
      .req_b_x   (req_b_x),
      .req_b_y   (req_b_y),
      .req_b_z   (req_b_z),
      .req_c_x   (req_c_x),
      .req_c_y   (req_c_y),
      .req_c_z   (req_c_z),
      .q_stat    (q_stat),
      .push      (push),
      .push_data (push_data)
   );

   tsn_queue #(.DATA_WIDTH(QW)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .q_stat    (q_stat)
   );

   tsn_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (!q_stat.empty),
      .q_data    (head),
      .q_pop     (pop),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_ctl   (rsp_ctl),
      .rsp_vec_x (rsp_vec_x),
      .rsp_vec_y (rsp_vec_y),
      .rsp_vec_z (rsp_vec_z),
      .rsp_area  (rsp_area)
   );

   assign rsp_vector_kind = rsp_ctl.kind;
   assign rsp_degenerate  = rsp_ctl.degenerate;
   assign rsp_last        = rsp_ctl.last;

   `TSN_ASSERT_IMPLY(a_queue_no_overflow, push, !q_stat.full, "queue written while full")
   `TSN_ASSERT_IMPLY(a_pop_not_empty, pop, !q_stat.empty, "queue read while empty")
   `TSN_ASSERT_IMPLY(a_degenerate_single, rsp_valid && rsp_degenerate, rsp_last && rsp_vector_kind == tsn_pkg::KIND_NORMAL && rsp_area == '0, "degenerate item malformed")
   `TSN_ASSERT_IMPLY(a_normal_not_last, rsp_valid && !rsp_degenerate && rsp_vector_kind == tsn_pkg::KIND_NORMAL, !rsp_last, "unit normal flagged last")

endmodule
